// ===== src/platform_interrupt_controller_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the platform interrupt controller
// Checks compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef PLATFORM_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define PIC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("pic assertion failed");
// Check that a condition in one cycle implies another in the next cycle.
`define PIC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pic assertion failed");
`else
`define PIC_ASSERT(label, clk, rstn, prop)
`define PIC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== src/pic_pkg.sv =====
// ---------------------------------------------------------------------------
// pic_pkg
// Sizes, register map and decode types of the platform interrupt controller.
// ---------------------------------------------------------------------------
package pic_pkg;

    localparam int NUM_SOURCES  = 32;
    localparam int NUM_CONTEXTS = 2;

    localparam int SRC_W  = $clog2(NUM_SOURCES);
    localparam int CTX_W  = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int CTXC_W = $clog2(NUM_CONTEXTS + 1);

    localparam int OFF_W   = 22;
    localparam int BYTES_W = 4;
    localparam int DATA_W  = 32;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 72;

    // Request kinds carried on tuser
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [BYTES_W-1:0] ACC_BYTES = 4'd4;

    // Register map
    localparam logic [OFF_W-1:0] PRIO_BASE   = 22'h000000;
    localparam logic [OFF_W-1:0] PRIO_SIZE   = 22'h001000;
    localparam logic [OFF_W-1:0] PEND_BASE   = 22'h001000;
    localparam logic [OFF_W-1:0] PEND_SIZE   = 22'h000080;
    localparam logic [OFF_W-1:0] ENAB_BASE   = 22'h002000;
    localparam logic [OFF_W-1:0] ENAB_SIZE   = 22'h1f0000;
    localparam logic [OFF_W-1:0] CTX_BASE    = 22'h200000;
    localparam logic [OFF_W-1:0] CTX_SIZE    = 22'h100000;
    localparam int               ENAB_STRIDE = 'h80;
    localparam int               CTX_STRIDE  = 'h1000;

    localparam int PRIO_AW = $clog2(int'(PRIO_SIZE));
    localparam int PEND_AW = $clog2(int'(PEND_SIZE));
    localparam int ENAB_SH = $clog2(ENAB_STRIDE);
    localparam int CTX_SH  = $clog2(CTX_STRIDE);

    localparam logic [CTX_SH-1:0] THR_OFS   = CTX_SH'(0);
    localparam logic [CTX_SH-1:0] CLAIM_OFS = CTX_SH'(4);

    localparam logic [DATA_W-1:0] SRC_MASK =
        DATA_W'((64'd1 << NUM_SOURCES) - 64'd1);

    // Decoded register access
    typedef struct packed {
        logic             aligned;
        logic             prio_hit;
        logic             src_ok;
        logic [SRC_W-1:0] src;
        logic             pend_hit;
        logic             pend_w0;
        logic             enab_hit;
        logic             enab_ok;
        logic             ctx_hit;
        logic             ctx_ok;
        logic [CTX_W-1:0] ctx;
        logic             thr_sel;
        logic             claim_sel;
    } pic_dec_t;

endpackage

// ===== src/pic_decode.sv =====
// ---------------------------------------------------------------------------
// pic_decode
// Splits a byte offset into register region, source or context index and
// word select.
// ---------------------------------------------------------------------------
module pic_decode (
    input  logic [pic_pkg::OFF_W-1:0]   offset,
    input  logic [pic_pkg::BYTES_W-1:0] access_bytes,
    output pic_pkg::pic_dec_t           dec
);

    logic [pic_pkg::OFF_W-1:0]     rel_prio;
    logic [pic_pkg::OFF_W-1:0]     rel_pend;
    logic [pic_pkg::OFF_W-1:0]     rel_enab;
    logic [pic_pkg::OFF_W-1:0]     rel_ctx;
    logic [pic_pkg::OFF_W-1:0]     enab_ctx;
    logic [pic_pkg::OFF_W-1:0]     ctx_idx;
    logic [pic_pkg::PRIO_AW-3:0]   src_word;

    always_comb begin
        rel_prio = offset - pic_pkg::PRIO_BASE;
        rel_pend = offset - pic_pkg::PEND_BASE;
        rel_enab = offset - pic_pkg::ENAB_BASE;
        rel_ctx  = offset - pic_pkg::CTX_BASE;
        enab_ctx = rel_enab >> pic_pkg::ENAB_SH;
        ctx_idx  = rel_ctx >> pic_pkg::CTX_SH;
        src_word = rel_prio[pic_pkg::PRIO_AW-1:2];

        dec.aligned  = (access_bytes == pic_pkg::ACC_BYTES) && (offset[1:0] == 2'b00);

        dec.prio_hit = (offset >= pic_pkg::PRIO_BASE) && (rel_prio < pic_pkg::PRIO_SIZE);
        dec.src_ok   = src_word < (pic_pkg::PRIO_AW-2)'(pic_pkg::NUM_SOURCES);
        dec.src      = src_word[pic_pkg::SRC_W-1:0];

        dec.pend_hit = (offset >= pic_pkg::PEND_BASE) && (rel_pend < pic_pkg::PEND_SIZE);
        dec.pend_w0  = rel_pend[pic_pkg::PEND_AW-1:2] == '0;

        dec.enab_hit = (offset >= pic_pkg::ENAB_BASE) && (rel_enab < pic_pkg::ENAB_SIZE);
        dec.enab_ok  = (enab_ctx < pic_pkg::OFF_W'(pic_pkg::NUM_CONTEXTS))
                    && (rel_enab[pic_pkg::ENAB_SH-1:2] == '0);

        dec.ctx_hit  = (offset >= pic_pkg::CTX_BASE) && (rel_ctx < pic_pkg::CTX_SIZE);
        dec.ctx_ok   = ctx_idx < pic_pkg::OFF_W'(pic_pkg::NUM_CONTEXTS);
        dec.thr_sel  = rel_ctx[pic_pkg::CTX_SH-1:0] == pic_pkg::THR_OFS;
        dec.claim_sel = rel_ctx[pic_pkg::CTX_SH-1:0] == pic_pkg::CLAIM_OFS;

        // One context index serves both regions that carry one
        dec.ctx = dec.enab_hit ? enab_ctx[pic_pkg::CTX_W-1:0] : ctx_idx[pic_pkg::CTX_W-1:0];
    end

endmodule

// ===== src/platform_interrupt_controller_core.sv =====
// ---------------------------------------------------------------------------
// platform_interrupt_controller_core
// Interrupt controller with per-source priority, pending and claimed state
// and per-context enable, threshold and claim registers.
// ---------------------------------------------------------------------------
//
//  channel | dir | ports                     | contents
//  --------+-----+---------------------------+----------------------------------
//  s_      | in  | tvalid tready tdata tuser | request: read, write or tick
//  m_      | out | tvalid tready tdata       | response: read data, ok, clears,
//          |     |                           |           context interrupt lines
//
//  Sequence: a read or write runs through EXEC and RESP (a priority read
//  also through PRIO_RD, for the memory port). A tick visits CTX for each
//  context, with SCAN and COMMIT for each context that holds no claim,
//  and then RESP: the priority memory has one read port, and the scan
//  streams sources 1 to NUM_SOURCES-1 through it with one compare each
//  cycle. A context that already holds a claim is skipped without a scan.
//  Reset: synchronous, active low; clears all priorities (through per-entry
//  valid bits), pending, claimed, enables, thresholds and claims.
//  Stalls: a new request is taken as soon as the previous one has been
//  processed, while its response may still wait in the output register.
//
`include "platform_interrupt_controller_core_defines.svh"

module platform_interrupt_controller_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [21:0] offset, [25:22] access_bytes, [57:26] write_data,
    // [89:58] source_lines, [95:90] zero
    input  logic [pic_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] op
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] read_data, [32] access_ok, [64:33] source_clear,
    // [66:65] context_irq, [71:67] zero
    output logic [pic_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int NS     = pic_pkg::NUM_SOURCES;
    localparam int NC     = pic_pkg::NUM_CONTEXTS;
    localparam int SRC_W  = pic_pkg::SRC_W;
    localparam int CTX_W  = pic_pkg::CTX_W;
    localparam int CTXC_W = pic_pkg::CTXC_W;
    localparam int DW     = pic_pkg::DATA_W;

    localparam logic [SRC_W-1:0] LAST_SRC = SRC_W'(NS - 1);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_EXEC    = 7'b0000010,
        ST_PRIO_RD = 7'b0000100,
        ST_CTX     = 7'b0001000,
        ST_SCAN    = 7'b0010000,
        ST_COMMIT  = 7'b0100000,
        ST_RESP    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Latched request (payload)
    logic [1:0]                    req_op_reg;
    logic [pic_pkg::OFF_W-1:0]     req_off_reg;
    logic [pic_pkg::BYTES_W-1:0]   req_bytes_reg;
    logic [DW-1:0]                 req_wdata_reg;
    logic [NS-1:0]                 req_lines_reg;

    // Controller state held in flops
    logic [NS-1:0]     pend_reg,     pend_next;
    logic [NS-1:0]     claimed_reg,  claimed_next;
    logic [NS-1:0]     prio_vld_reg, prio_vld_next;
    logic [DW-1:0]     enable_reg [NC];
    logic [DW-1:0]     enable_next [NC];
    logic [DW-1:0]     thr_reg [NC];
    logic [DW-1:0]     thr_next [NC];
    logic [SRC_W-1:0]  claim_reg [NC];
    logic [SRC_W-1:0]  claim_next [NC];

    // Scan sequencer
    logic [CTXC_W-1:0] ctx_reg,       ctx_next;
    logic [SRC_W-1:0]  iss_reg,       iss_next;
    logic              iss_done_reg,  iss_done_next;
    logic              cmp_vld_reg,   cmp_vld_next;
    logic [SRC_W-1:0]  cmp_idx_reg,   cmp_idx_next;
    logic [SRC_W-1:0]  best_idx_reg,  best_idx_next;
    logic [DW-1:0]     best_prio_reg, best_prio_next;

    // Response under construction
    logic [DW-1:0]     rd_reg,  rd_next;
    logic              ok_reg,  ok_next;
    logic [NS-1:0]     clr_reg, clr_next;

    // Output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [pic_pkg::M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;

    // Priority memory, one port each way, registered read
    logic [DW-1:0]     prio_mem [NS];
    logic [DW-1:0]     prio_rd_reg;
    logic              prio_rd_vld_reg;
    logic              mem_re;
    logic              mem_we;
    logic [SRC_W-1:0]  mem_raddr;
    logic [SRC_W-1:0]  mem_waddr;
    logic [DW-1:0]     mem_wdata;

    pic_pkg::pic_dec_t dec;

    logic [CTX_W-1:0]  cidx;
    logic [DW-1:0]     cand_prio;
    logic              cand_win;
    logic [NC-1:0]     irq;
    logic              claim_ok;

    pic_decode u_decode (
        .offset       (req_off_reg),
        .access_bytes (req_bytes_reg),
        .dec          (dec)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cidx = ctx_reg[CTX_W-1:0];

    // An unwritten priority entry reads as zero
    assign cand_prio = prio_rd_vld_reg ? prio_rd_reg : '0;
    assign cand_win  = pend_reg[cmp_idx_reg] && !claimed_reg[cmp_idx_reg]
                    && enable_reg[cidx][cmp_idx_reg] && (cand_prio > best_prio_reg);

    always_comb begin
        irq      = '0;
        claim_ok = 1'b1;
        for (int c = 0; c < NC; c++) begin
            irq[c] = claim_reg[c] != '0;
            if (claim_reg[c] != '0 && !claimed_reg[claim_reg[c]]) begin
                claim_ok = 1'b0;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        claimed_next   = claimed_reg;
        prio_vld_next  = prio_vld_reg;
        enable_next    = enable_reg;
        thr_next       = thr_reg;
        claim_next     = claim_reg;
        ctx_next       = ctx_reg;
        iss_next       = iss_reg;
        iss_done_next  = iss_done_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        rd_next        = rd_reg;
        ok_next        = ok_reg;
        clr_next       = clr_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_raddr      = iss_reg;
        mem_waddr      = dec.src;
        mem_wdata      = req_wdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rd_next    = '0;
                    ok_next    = 1'b0;
                    clr_next   = '0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_RESP;
                case (req_op_reg)
                    pic_pkg::OP_READ: begin
                        if (dec.aligned) begin
                            if (dec.prio_hit) begin
                                ok_next = 1'b1;
                                if (dec.src_ok) begin
                                    // Fetch from memory, finish next cycle
                                    mem_re     = 1'b1;
                                    mem_raddr  = dec.src;
                                    state_next = ST_PRIO_RD;
                                end
                            end else if (dec.pend_hit) begin
                                ok_next = 1'b1;
                                if (dec.pend_w0) begin
                                    rd_next = DW'(pend_reg);
                                end
                            end else if (dec.enab_hit) begin
                                ok_next = 1'b1;
                                if (dec.enab_ok) begin
                                    rd_next = enable_reg[dec.ctx];
                                end
                            end else if (dec.ctx_hit) begin
                                ok_next = 1'b1;
                                if (dec.ctx_ok && dec.thr_sel) begin
                                    rd_next = thr_reg[dec.ctx];
                                end else if (dec.ctx_ok && dec.claim_sel) begin
                                    rd_next = DW'(claim_reg[dec.ctx]);
                                end
                            end
                        end
                    end
                    pic_pkg::OP_WRITE: begin
                        if (dec.aligned) begin
                            if (dec.prio_hit) begin
                                ok_next = 1'b1;
                                if (dec.src_ok) begin
                                    mem_we                 = 1'b1;
                                    prio_vld_next[dec.src] = 1'b1;
                                end
                            end else if (dec.enab_hit) begin
                                ok_next = 1'b1;
                                if (dec.enab_ok) begin
                                    enable_next[dec.ctx] =
                                        req_wdata_reg & pic_pkg::SRC_MASK & ~DW'(1);
                                end
                            end else if (dec.ctx_hit && dec.ctx_ok) begin
                                if (dec.thr_sel) begin
                                    ok_next            = 1'b1;
                                    thr_next[dec.ctx]  = req_wdata_reg;
                                end else if (dec.claim_sel) begin
                                    ok_next = 1'b1;
                                    // Complete only the ID this context holds
                                    if (req_wdata_reg == DW'(claim_reg[dec.ctx])
                                            && req_wdata_reg < DW'(NS)) begin
                                        claimed_next[req_wdata_reg[SRC_W-1:0]] = 1'b0;
                                        claim_next[dec.ctx] = '0;
                                    end
                                end
                            end
                        end
                    end
                    pic_pkg::OP_TICK: begin
                        ok_next    = 1'b1;
                        pend_next  = pend_reg | (req_lines_reg & ~NS'(1));
                        ctx_next   = '0;
                        state_next = ST_CTX;
                    end
                    default: begin
                        // Undefined request kind: no state change
                    end
                endcase
            end

            ST_PRIO_RD: begin
                rd_next    = cand_prio;
                state_next = ST_RESP;
            end

            ST_CTX: begin
                if (ctx_reg == CTXC_W'(NC)) begin
                    state_next = ST_RESP;
                end else if (claim_reg[cidx] != '0) begin
                    ctx_next = ctx_reg + CTXC_W'(1);
                end else begin
                    iss_next       = SRC_W'(1);
                    iss_done_next  = 1'b0;
                    best_idx_next  = '0;
                    best_prio_next = thr_reg[cidx];
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Issue one source a cycle, compare the one read last cycle
                if (!iss_done_reg) begin
                    mem_re       = 1'b1;
                    mem_raddr    = iss_reg;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = iss_reg;
                    if (iss_reg == LAST_SRC) begin
                        iss_done_next = 1'b1;
                    end else begin
                        iss_next = iss_reg + SRC_W'(1);
                    end
                end
                if (cmp_vld_reg) begin
                    if (cand_win) begin
                        best_idx_next  = cmp_idx_reg;
                        best_prio_next = cand_prio;
                    end
                    if (cmp_idx_reg == LAST_SRC) begin
                        state_next = ST_COMMIT;
                    end
                end
            end

            ST_COMMIT: begin
                if (best_idx_reg != '0) begin
                    pend_next[best_idx_reg]    = 1'b0;
                    claimed_next[best_idx_reg] = 1'b1;
                    claim_next[cidx]           = best_idx_reg;
                    clr_next[best_idx_reg]     = 1'b1;
                end
                ctx_next   = ctx_reg + CTXC_W'(1);
                state_next = ST_CTX;
            end

            ST_RESP: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pic_pkg::M_TDATA_W'({2'(irq), DW'(clr_reg), ok_reg, rd_reg});
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Priority memory; a write comes only from a write request and a read only
    // from a read request or a scan, so no access to the same entry can overlap
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            prio_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            prio_rd_reg     <= prio_mem[mem_raddr];
            prio_rd_vld_reg <= prio_vld_reg[mem_raddr];
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_op_reg    <= s_tuser;
            req_off_reg   <= s_tdata[21:0];
            req_bytes_reg <= s_tdata[25:22];
            req_wdata_reg <= s_tdata[57:26];
            req_lines_reg <= s_tdata[58 +: NS];
        end
    end

    // Payload of the sequencer and response
    always_ff @(posedge aclk) begin
        iss_next_hold: begin
            iss_reg       <= iss_next;
            cmp_idx_reg   <= cmp_idx_next;
            best_idx_reg  <= best_idx_next;
            best_prio_reg <= best_prio_next;
            rd_reg        <= rd_next;
            ok_reg        <= ok_next;
            clr_reg       <= clr_next;
            m_tdata_reg   <= m_tdata_next;
        end
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= '0;
            claimed_reg  <= '0;
            prio_vld_reg <= '0;
            enable_reg   <= '{default: '0};
            thr_reg      <= '{default: '0};
            claim_reg    <= '{default: '0};
            ctx_reg      <= '0;
            iss_done_reg <= 1'b1;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            claimed_reg  <= claimed_next;
            prio_vld_reg <= prio_vld_next;
            enable_reg   <= enable_next;
            thr_reg      <= thr_next;
            claim_reg    <= claim_next;
            ctx_reg      <= ctx_next;
            iss_done_reg <= iss_done_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Every live claim keeps its source marked as claimed
    `PIC_ASSERT(a_claim_held, aclk, aresetn, claim_ok)
    // The memory port never reads and writes in the same cycle
    `PIC_ASSERT(a_mem_one_access, aclk, aresetn, !(mem_we && mem_re))
    // A tick claims at most one source per context
    `PIC_ASSERT(a_clear_bound, aclk, aresetn, $countones(clr_reg) <= NC)
    // The last compare of a scan always leads to the commit step
    `PIC_ASSERT_NEXT(a_scan_commit, aclk, aresetn, state_reg == ST_SCAN && cmp_vld_reg && cmp_idx_reg == LAST_SRC, state_reg == ST_COMMIT)

endmodule

// ===== verif/platform_interrupt_controller_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// platform_interrupt_controller_core_tb
// Self-checking bench for the interrupt controller core. Bus reads, bus
// writes and ticks go in on the request stream. A behavioral model of the
// priority, pending, claimed, enable, threshold and claim state predicts
// each response. Every response is checked field by field against the
// oldest prediction, under several idle and stall patterns on both sides.
// ----------------------------------------------------------------------------

module platform_interrupt_controller_core_tb;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int MAX_REPORTS    = 10;

    localparam int N_SRC   = pic_pkg::NUM_SOURCES;
    localparam int N_CTX   = pic_pkg::NUM_CONTEXTS;
    localparam int CLAIM_W = pic_pkg::SRC_W;

    localparam logic [1:0] OP_READ    = pic_pkg::OP_READ;
    localparam logic [1:0] OP_WRITE   = pic_pkg::OP_WRITE;
    localparam logic [1:0] OP_TICK    = pic_pkg::OP_TICK;
    // The request kind field has one more code, which the core must reject.
    localparam logic [1:0] OP_INVALID = 2'd3;

    localparam logic [3:0] WORD_BYTES = pic_pkg::ACC_BYTES;

    // Register map, kept apart from the package so that a wrong map shows up.
    localparam int unsigned REG_PRIO_BASE   = 'h000000;
    localparam int unsigned REG_PRIO_SIZE   = 'h001000;
    localparam int unsigned REG_PEND_BASE   = 'h001000;
    localparam int unsigned REG_PEND_SIZE   = 'h000080;
    localparam int unsigned REG_ENAB_BASE   = 'h002000;
    localparam int unsigned REG_ENAB_SIZE   = 'h1f0000;
    localparam int unsigned REG_CTX_BASE    = 'h200000;
    localparam int unsigned REG_CTX_SIZE    = 'h100000;
    localparam int unsigned REG_ENAB_STRIDE = 'h80;
    localparam int unsigned REG_CTX_STRIDE  = 'h1000;
    localparam int unsigned REG_THR_WORD    = 0;
    localparam int unsigned REG_CLAIM_WORD  = 4;

    localparam logic [31:0] SRC_BITS = 32'((64'd1 << N_SRC) - 64'd1);

    typedef enum logic [2:0] {
        RGN_NONE,
        RGN_PRIO,
        RGN_PEND,
        RGN_ENAB,
        RGN_CTX
    } map_region_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        ok;
        logic [31:0] clear;
        logic [1:0]  irq;
    } pic_resp_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [pic_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]                     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pic_pkg::M_TDATA_W-1:0]  m_tdata;

    // Idle and stall chances in percent per cycle; set per traffic phase.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // Model state of the controller.
    logic [31:0]        prio_level      [N_SRC];
    logic [31:0]        pend_mask;
    logic [31:0]        claimed_mask;
    logic [31:0]        enable_mask     [N_CTX];
    logic [31:0]        threshold_level [N_CTX];
    logic [CLAIM_W-1:0] claim_id        [N_CTX];

    // Responses still owed by the core, oldest first.
    pic_resp_t responses_due[$];

    platform_interrupt_controller_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Advance the model by one request and return the response it owes.
    function automatic pic_resp_t plic_step(input logic [1:0]  op,
                                            input logic [21:0] offset,
                                            input logic [3:0]  nbytes,
                                            input logic [31:0] wdata,
                                            input logic [31:0] lines);
        pic_resp_t   r;
        map_region_t rgn;
        int unsigned off, idx, sub, best;
        logic [31:0] best_level;
        bit          word_ok;
        r       = '0;
        off     = offset;
        idx     = 0;
        sub     = 0;
        word_ok = (nbytes == WORD_BYTES) && (offset[1:0] == 2'b00);

        // Decode the region, then the source or context and the word in it.
        if (off >= REG_PRIO_BASE && off - REG_PRIO_BASE < REG_PRIO_SIZE) begin
            rgn = RGN_PRIO;
            idx = (off - REG_PRIO_BASE) / 4;
        end else if (off >= REG_PEND_BASE && off - REG_PEND_BASE < REG_PEND_SIZE) begin
            rgn = RGN_PEND;
            sub = off - REG_PEND_BASE;
        end else if (off >= REG_ENAB_BASE && off - REG_ENAB_BASE < REG_ENAB_SIZE) begin
            rgn = RGN_ENAB;
            idx = (off - REG_ENAB_BASE) / REG_ENAB_STRIDE;
            sub = (off - REG_ENAB_BASE) % REG_ENAB_STRIDE;
        end else if (off >= REG_CTX_BASE && off - REG_CTX_BASE < REG_CTX_SIZE) begin
            rgn = RGN_CTX;
            idx = (off - REG_CTX_BASE) / REG_CTX_STRIDE;
            sub = (off - REG_CTX_BASE) % REG_CTX_STRIDE;
        end else begin
            rgn = RGN_NONE;
        end

        case (op)
            OP_READ: begin
                if (word_ok) begin
                    case (rgn)
                        RGN_PRIO: begin
                            r.ok = 1'b1;
                            if (idx < N_SRC) r.rdata = prio_level[idx];
                        end
                        RGN_PEND: begin
                            r.ok = 1'b1;
                            if (sub == 0) r.rdata = pend_mask;
                        end
                        RGN_ENAB: begin
                            r.ok = 1'b1;
                            if (idx < N_CTX && sub == 0) r.rdata = enable_mask[idx];
                        end
                        RGN_CTX: begin
                            r.ok = 1'b1;
                            if (idx < N_CTX && sub == REG_THR_WORD)
                                r.rdata = threshold_level[idx];
                            else if (idx < N_CTX && sub == REG_CLAIM_WORD)
                                r.rdata = 32'(claim_id[idx]);
                        end
                        default: ;
                    endcase
                end
            end
            OP_WRITE: begin
                if (word_ok) begin
                    case (rgn)
                        RGN_PRIO: begin
                            r.ok = 1'b1;
                            if (idx < N_SRC) prio_level[idx] = wdata;
                        end
                        RGN_ENAB: begin
                            r.ok = 1'b1;
                            // Drop source 0 and sources that do not exist.
                            if (idx < N_CTX && sub == 0)
                                enable_mask[idx] = wdata & SRC_BITS & ~32'd1;
                        end
                        RGN_CTX: begin
                            if (idx < N_CTX && sub == REG_THR_WORD) begin
                                r.ok                 = 1'b1;
                                threshold_level[idx] = wdata;
                            end else if (idx < N_CTX && sub == REG_CLAIM_WORD) begin
                                r.ok = 1'b1;
                                // Complete only on the ID that is held.
                                if (wdata == 32'(claim_id[idx]) && wdata < N_SRC) begin
                                    claimed_mask[wdata] = 1'b0;
                                    claim_id[idx]       = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_TICK: begin
                r.ok      = 1'b1;
                pend_mask = pend_mask | (lines & SRC_BITS & ~32'd1);
                for (int unsigned c = 0; c < N_CTX; c++) begin
                    if (claim_id[c] == '0) begin
                        best       = 0;
                        best_level = threshold_level[c];
                        // Strictly greater: the lowest index keeps a tie.
                        for (int unsigned s = 1; s < N_SRC; s++) begin
                            if (pend_mask[s] && !claimed_mask[s] && enable_mask[c][s] &&
                                prio_level[s] > best_level) begin
                                best_level = prio_level[s];
                                best       = s;
                            end
                        end
                        if (best != 0) begin
                            pend_mask[best]    = 1'b0;
                            claimed_mask[best] = 1'b1;
                            claim_id[c]        = CLAIM_W'(best);
                            r.clear[best]      = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        for (int unsigned c = 0; c < N_CTX; c++)
            r.irq[c] = (claim_id[c] != '0);
        return r;
    endfunction

    // Present one request, hold it until the core takes it, then log the
    // response that the core owes for it.
    task automatic send_request(input logic [1:0]  op,
                                input logic [21:0] offset,
                                input logic [3:0]  nbytes,
                                input logic [31:0] wdata,
                                input logic [31:0] lines);
        @(negedge aclk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, lines, wdata, nbytes, offset};
        do @(posedge aclk); while (!s_tready);
        responses_due.push_back(plic_step(op, offset, nbytes, wdata, lines));
    endtask

    // Hold off new requests until every owed response has come back.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (responses_due.size() != 0) @(posedge aclk);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    endtask

    // Size, alignment and region errors, plus the reserved request kind.
    task automatic test_bus_errors();
        send_request(OP_READ, 22'(REG_PRIO_BASE), 4'd8, '0, '0);
        send_request(OP_READ, 22'(REG_PRIO_BASE + 4), 4'hf, '0, '0);
        send_request(OP_WRITE, 22'(REG_PRIO_BASE + 2), WORD_BYTES, '1, '0);
        send_request(OP_READ, 22'h3fffff, 4'd1, '0, '1);
        send_request(OP_READ, 22'h3ffffc, WORD_BYTES, '0, '0);
        send_request(OP_READ, 22'(REG_PEND_BASE + REG_PEND_SIZE), WORD_BYTES, '0, '0);
        send_request(OP_WRITE, 22'(REG_PEND_BASE), WORD_BYTES, '1, '0);
        send_request(OP_WRITE, 22'(REG_CTX_BASE + N_CTX * REG_CTX_STRIDE + REG_THR_WORD),
                     WORD_BYTES, '1, '0);
        send_request(OP_WRITE, 22'(REG_CTX_BASE + 8), WORD_BYTES, '1, '0);
        send_request(OP_INVALID, 22'(REG_PRIO_BASE), WORD_BYTES, '1, '1);
    endtask

    // Words that exist in the map but hold nothing, and masked enables.
    task automatic test_register_map();
        send_request(OP_WRITE, 22'(REG_PRIO_BASE + 4 * N_SRC), WORD_BYTES, '1, '0);
        send_request(OP_READ, 22'(REG_PRIO_BASE + 4 * N_SRC), WORD_BYTES, '0, '0);
        send_request(OP_WRITE, 22'(REG_PRIO_BASE), WORD_BYTES, '1, '0);
        send_request(OP_READ, 22'(REG_PRIO_BASE), WORD_BYTES, '0, '0);
        send_request(OP_WRITE, 22'(REG_ENAB_BASE), WORD_BYTES, '1, '0);
        send_request(OP_READ, 22'(REG_ENAB_BASE), WORD_BYTES, '0, '0);
        send_request(OP_WRITE, 22'(REG_ENAB_BASE + N_CTX * REG_ENAB_STRIDE), WORD_BYTES, '1, '0);
        send_request(OP_WRITE, 22'(REG_ENAB_BASE + 4), WORD_BYTES, '1, '0);
        send_request(OP_READ, 22'(REG_PEND_BASE + 4), WORD_BYTES, '0, '0);
        send_request(OP_READ, 22'(REG_CTX_BASE + N_CTX * REG_CTX_STRIDE + REG_CLAIM_WORD),
                     WORD_BYTES, '0, '0);
        send_request(OP_READ, 22'(REG_CTX_BASE + 8), WORD_BYTES, '0, '0);
    endtask

    // Threshold at its maximum, a priority tie, bad completions, then a good one.
    task automatic test_claim_flow();
        logic [21:0] claim1;
        claim1 = 22'(REG_CTX_BASE + REG_CTX_STRIDE + REG_CLAIM_WORD);
        send_request(OP_WRITE, 22'(REG_PRIO_BASE + 4 * 5), WORD_BYTES, 32'd7, '0);
        send_request(OP_WRITE, 22'(REG_PRIO_BASE + 4 * 9), WORD_BYTES, 32'd7, '0);
        send_request(OP_WRITE, 22'(REG_ENAB_BASE + REG_ENAB_STRIDE), WORD_BYTES,
                     (32'd1 << 5) | (32'd1 << 9), '0);
        send_request(OP_WRITE, 22'(REG_CTX_BASE + REG_THR_WORD), WORD_BYTES, '1, '0);
        send_request(OP_TICK, '0, '0, '0, '1);
        send_request(OP_WRITE, claim1, WORD_BYTES, 32'd9, '0);
        send_request(OP_WRITE, claim1, WORD_BYTES, '1, '0);
        send_request(OP_READ, claim1, WORD_BYTES, '0, '0);
        send_request(OP_WRITE, claim1, WORD_BYTES, 32'd5, '0);
        send_request(OP_TICK, '0, '0, '0, '0);
    endtask

    // Mostly well-formed traffic: set up sources and contexts, tick, complete
    // claims; the rest is reads and raw noise.
    task automatic test_random_traffic(input int count, input int unsigned idle_pct,
                                       input int unsigned stall);
        int unsigned c, s, pick;
        logic [31:0] level, lines;
        logic [21:0] offset;
        logic [3:0]  nbytes;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int i = 0; i < count; i++) begin
            c     = $urandom_range(N_CTX - 1, 0);
            s     = $urandom_range(N_SRC - 1, 1);
            level = ($urandom_range(9, 0) == 0) ? $urandom : 32'($urandom_range(7, 0));
            pick  = $urandom_range(99, 0);
            if (pick < 30) begin
                // Thin the lines out half the time so that claims stay contested.
                lines = $urandom;
                if ($urandom_range(1, 0) == 1) lines = lines & $urandom & $urandom;
                send_request(OP_TICK, 22'($urandom), 4'($urandom), $urandom, lines);
            end else if (pick < 45) begin
                send_request(OP_WRITE, 22'(REG_CTX_BASE + c * REG_CTX_STRIDE + REG_CLAIM_WORD),
                             WORD_BYTES, 32'(claim_id[c]), $urandom);
            end else if (pick < 63) begin
                if ($urandom_range(15, 0) == 0) s = 0;
                send_request(OP_WRITE, 22'(REG_PRIO_BASE + 4 * s), WORD_BYTES, level, $urandom);
            end else if (pick < 72) begin
                send_request(OP_WRITE, 22'(REG_ENAB_BASE + c * REG_ENAB_STRIDE), WORD_BYTES,
                             $urandom, $urandom);
            end else if (pick < 79) begin
                send_request(OP_WRITE, 22'(REG_CTX_BASE + c * REG_CTX_STRIDE + REG_THR_WORD),
                             WORD_BYTES, level, $urandom);
            end else if (pick < 92) begin
                case ($urandom_range(4, 0))
                    0:       offset = 22'(REG_PRIO_BASE + 4 * s);
                    1:       offset = 22'(REG_PEND_BASE);
                    2:       offset = 22'(REG_ENAB_BASE + c * REG_ENAB_STRIDE);
                    3:       offset = 22'(REG_CTX_BASE + c * REG_CTX_STRIDE + REG_THR_WORD);
                    default: offset = 22'(REG_CTX_BASE + c * REG_CTX_STRIDE + REG_CLAIM_WORD);
                endcase
                send_request(OP_READ, offset, WORD_BYTES, $urandom, $urandom);
            end else begin
                // Raw noise; half of it as aligned words so the holes in the map get hit.
                offset = 22'($urandom);
                nbytes = 4'($urandom);
                if ($urandom_range(1, 0) == 1) begin
                    offset[1:0] = 2'b00;
                    nbytes      = WORD_BYTES;
                end
                send_request(2'($urandom), offset, nbytes, $urandom, $urandom);
            end
            if ($urandom_range(49, 0) == 0) wait_for_drain();
        end
    endtask

    // Receiver: stall at random at the current rate.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Compare every response taken from the core with the oldest one owed.
    always @(posedge aclk) begin
        pic_resp_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (responses_due.size() == 0) begin
                note_mismatch("unrequested response, read_data", '0, m_tdata[31:0]);
            end else begin
                due = responses_due.pop_front();
                if (m_tdata[31:0] !== due.rdata)
                    note_mismatch("read_data", due.rdata, m_tdata[31:0]);
                if (m_tdata[32] !== due.ok)
                    note_mismatch("access_ok", 32'(due.ok), 32'(m_tdata[32]));
                if (m_tdata[64:33] !== due.clear)
                    note_mismatch("source_clear", due.clear, m_tdata[64:33]);
                if (m_tdata[66:65] !== due.irq)
                    note_mismatch("context_irq", 32'(due.irq), 32'(m_tdata[66:65]));
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("platform_interrupt_controller_core regression: fail");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < N_SRC; s++) prio_level[s] = '0;
        for (int c = 0; c < N_CTX; c++) begin
            enable_mask[c]     = '0;
            threshold_level[c] = '0;
            claim_id[c]        = '0;
        end
        pend_mask    = '0;
        claimed_mask = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_bus_errors();
        test_register_map();
        test_claim_flow();
        wait_for_drain();

        test_random_traffic(175, 0, 0);
        wait_for_drain();
        test_random_traffic(175, 60, 0);
        wait_for_drain();
        test_random_traffic(175, 0, 60);
        wait_for_drain();
        test_random_traffic(175, 29, 29);
        wait_for_drain();

        // Catch any stray response after the last one owed.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        mismatch_count += responses_due.size();
        if (mismatch_count == 0)
            $display("platform_interrupt_controller_core regression: pass");
        else
            $display("platform_interrupt_controller_core regression: fail");
        $finish;
    end

endmodule
